// File: hdl/mpls_pkg.sv
// ----------------------------------------------------------------------------
// mpls_pkg: shared types and constants of the motor power limit scaler
// Widths, register indexes, controller states, multiplier operations and
// the command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mpls_pkg;

    // Samples per mean of modeled power; the mean is formed by a shift.
    localparam int AVERAGE_WINDOW = 64;
    localparam int WIN_SHIFT      = $clog2(AVERAGE_WINDOW);

    localparam int COEF_W = 48;
    localparam int ACC_W  = 96;
    localparam int Q_W    = 40;
    localparam int DISC_W = 84;
    localparam int ROOT_W = 42;

    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = 15;

    localparam logic [15:0] SCALE_ONE = 16'd32768;
    localparam logic [15:0] TOL_RESET = 16'd1280;

    // Configuration register indexes.
    localparam logic [2:0] CFG_COEF_CONSTANT   = 3'd0;
    localparam logic [2:0] CFG_COEF_CURRENT    = 3'd1;
    localparam logic [2:0] CFG_COEF_SPEED      = 3'd2;
    localparam logic [2:0] CFG_COEF_CROSS      = 3'd3;
    localparam logic [2:0] CFG_COEF_CURRENT_SQ = 3'd4;
    localparam logic [2:0] CFG_COEF_SPEED_SQ   = 3'd5;
    localparam logic [2:0] CFG_MATCH_TOL       = 3'd6;

    // Operations of the shared multiplier, issued in this order.
    typedef enum logic [4:0] {
        MUL_CS, MUL_CC, MUL_SS, MUL_K1I, MUL_K2W,
        MUL_K3_HI, MUL_K3_LO, MUL_K4_HI, MUL_K4_LO, MUL_K5_HI, MUL_K5_LO,
        MUL_AC0, MUL_AC1, MUL_AC2, MUL_BB0, MUL_BB1, MUL_BB2
    } t_mul_op;

    typedef enum logic [3:0] {
        ST_IDLE, ST_MUL, ST_MUL_DRAIN, ST_TOTAL, ST_MODEL, ST_MATCH, ST_DECIDE,
        ST_DMUL, ST_DMUL_DRAIN, ST_DISC, ST_CHECK, ST_SQRT, ST_DIV_CHECK,
        ST_DIV, ST_SCALE, ST_OUT
    } t_state;

    typedef struct packed {
        logic signed [15:0] motor_current;
        logic signed [15:0] motor_speed;
        logic [19:0]        measured_power;
        logic [19:0]        power_target;
    } t_in_item;

    typedef struct packed {
        logic [15:0]        speed_scale;
        logic signed [23:0] predicted_power;
        logic               model_matches;
    } t_out_item;

    typedef struct packed {
        logic    load;
        logic    mul_en;
        t_mul_op mul_op;
        logic    total_en;
        logic    model_en;
        logic    match_en;
        logic    disc_en;
        logic    sqrt_init;
        logic    sqrt_step;
        logic    div_init;
        logic    div_step;
        logic    scale_one;
        logic    scale_div;
        logic    out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic match;
        logic over_target;
        logic disc_ok;
        logic div_sat;
        logic out_free;
    } t_dp_stat;

endpackage

// File: hdl/mpls_if.sv
// ----------------------------------------------------------------------------
// mpls_if: item channels of the motor power limit scaler
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface mpls_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] motor_current;
    logic signed [15:0] motor_speed;
    logic [19:0]        measured_power;
    logic [19:0]        power_target;

    modport source (output valid, motor_current, motor_speed, measured_power,
                    power_target, input ready);
    modport sink   (input valid, motor_current, motor_speed, measured_power,
                    power_target, output ready);
endinterface

interface mpls_out_if;
    logic               valid;
    logic               ready;
    logic [15:0]        speed_scale;
    logic signed [23:0] predicted_power;
    logic               model_matches;

    modport source (output valid, speed_scale, predicted_power, model_matches,
                    input ready);
    modport sink   (input valid, speed_scale, predicted_power, model_matches,
                    output ready);
endinterface

// File: hdl/mpls_ctrl.sv
// ----------------------------------------------------------------------------
// mpls_ctrl: sequencer of the motor power limit scaler
// Steps the datapath through model products, averaging, the quadratic
// solve (square root and division) and the hand-off to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpls_ctrl import mpls_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_fire,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state     r_state, n_state;
    t_mul_op    r_op, n_op;
    logic [5:0] r_cnt, n_cnt;

    // State, operation and step counter registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_op    <= MUL_CS;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
            r_cnt   <= n_cnt;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        n_cnt   = r_cnt;
        case (r_state)
            ST_IDLE: begin
                if (i_in_fire) begin
                    n_state = ST_MUL;
                    n_op    = MUL_CS;
                end
            end
            ST_MUL: begin
                if (r_op == MUL_K5_LO) n_state = ST_MUL_DRAIN;
                else n_op = t_mul_op'(5'(r_op + 5'd1));
            end
            ST_MUL_DRAIN: n_state = ST_TOTAL;
            ST_TOTAL:     n_state = ST_MODEL;
            ST_MODEL:     n_state = ST_MATCH;
            ST_MATCH:     n_state = ST_DECIDE;
            ST_DECIDE: begin
                if (i_stat.match && i_stat.over_target) begin
                    n_state = ST_DMUL;
                    n_op    = MUL_AC0;
                end else begin
                    n_state = ST_OUT;
                end
            end
            ST_DMUL: begin
                if (r_op == MUL_BB2) n_state = ST_DMUL_DRAIN;
                else n_op = t_mul_op'(5'(r_op + 5'd1));
            end
            ST_DMUL_DRAIN: n_state = ST_DISC;
            ST_DISC:       n_state = ST_CHECK;
            ST_CHECK: begin
                n_cnt   = '0;
                n_state = i_stat.disc_ok ? ST_SQRT : ST_OUT;
            end
            ST_SQRT: begin
                if (r_cnt == 6'(SQRT_STEPS - 1)) n_state = ST_DIV_CHECK;
                else n_cnt = r_cnt + 6'd1;
            end
            ST_DIV_CHECK: begin
                n_cnt   = '0;
                n_state = i_stat.div_sat ? ST_OUT : ST_DIV;
            end
            ST_DIV: begin
                if (r_cnt == 6'(DIV_STEPS - 1)) n_state = ST_SCALE;
                else n_cnt = r_cnt + 6'd1;
            end
            ST_SCALE: n_state = ST_OUT;
            ST_OUT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd        = '0;
        o_cmd.mul_op = r_op;
        o_in_ready   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_fire;
            end
            ST_MUL:   o_cmd.mul_en   = 1'b1;
            ST_TOTAL: o_cmd.total_en = 1'b1;
            ST_MODEL: o_cmd.model_en = 1'b1;
            ST_MATCH: o_cmd.match_en = 1'b1;
            ST_DECIDE: begin
                o_cmd.scale_one = i_stat.match && !i_stat.over_target;
            end
            ST_DMUL:      o_cmd.mul_en    = 1'b1;
            ST_DISC:      o_cmd.disc_en   = 1'b1;
            ST_CHECK:     o_cmd.sqrt_init = i_stat.disc_ok;
            ST_SQRT:      o_cmd.sqrt_step = 1'b1;
            ST_DIV_CHECK: begin
                o_cmd.scale_one = i_stat.div_sat;
                o_cmd.div_init  = !i_stat.div_sat;
            end
            ST_DIV:   o_cmd.div_step  = 1'b1;
            ST_SCALE: o_cmd.scale_div = 1'b1;
            ST_OUT:   o_cmd.out_load  = i_stat.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: hdl/mpls_dp.sv
// ----------------------------------------------------------------------------
// mpls_dp: datapath of the motor power limit scaler
// Configuration registers, the shared 48x17 multiplier with accumulators,
// the running mean, the quadratic coefficients, a radix-2 square root,
// a restoring divider and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpls_dp import mpls_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    input  t_dp_cmd     i_cmd,
    input  t_in_item    i_item,
    input  logic        i_out_ready,
    output t_dp_stat    o_stat,
    output logic        o_out_valid,
    output t_out_item   o_out
);

    // Saturate a Q.8 value, already shifted, to 40 signed bits.
    function automatic logic signed [Q_W-1:0] sat40(input logic signed [63:0] v);
        logic signed [Q_W-1:0] r;
        if ((&v[63:Q_W-1]) || !(|v[63:Q_W-1])) r = v[Q_W-1:0];
        else r = v[63] ? {1'b1, {(Q_W-1){1'b0}}} : {1'b0, {(Q_W-1){1'b1}}};
        return r;
    endfunction

    // Configuration.
    logic signed [COEF_W-1:0] r_k [6];
    logic [15:0]              r_tol;

    // Item and products.
    logic signed [15:0]      r_cur, r_spd;
    logic [19:0]             r_meas, r_target;
    logic signed [31:0]      r_pcs, r_pcc, r_pss;
    logic signed [64:0]      r_prod;
    t_mul_op                 r_acc_op;
    logic                    r_acc_en;
    logic signed [ACC_W-1:0] r_acc_a, r_acc_b, r_acc_c, r_total;
    logic signed [DISC_W-1:0] r_ac, r_bb, r_disc;

    // Running model state.
    logic signed [31:0]          r_sum;
    logic [WIN_SHIFT-1:0]        r_count;
    logic signed [23:0]          r_mean;
    logic                        r_match;
    logic [15:0]                 r_scale;

    // Quadratic solve.
    logic signed [Q_W-1:0] r_qa, r_qb, r_qc;
    logic [DISC_W-1:0]     r_rad;
    logic [44:0]           r_rem;
    logic [ROOT_W-1:0]     r_root;
    logic [43:0]           r_drem;
    logic [15:0]           r_quot;

    // Output register.
    logic      r_out_valid;
    t_out_item r_out;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) r_k[i] <= '0;
            r_tol <= TOL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_COEF_CONSTANT:   r_k[0] <= i_cfg_data;
                CFG_COEF_CURRENT:    r_k[1] <= i_cfg_data;
                CFG_COEF_SPEED:      r_k[2] <= i_cfg_data;
                CFG_COEF_CROSS:      r_k[3] <= i_cfg_data;
                CFG_COEF_CURRENT_SQ: r_k[4] <= i_cfg_data;
                CFG_COEF_SPEED_SQ:   r_k[5] <= i_cfg_data;
                CFG_MATCH_TOL:       r_tol  <= i_cfg_data[15:0];
                default:             r_tol  <= r_tol;
            endcase
        end
    end

    // Operand selection of the shared multiplier; wide factors go in 16-bit chunks.
    logic signed [47:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [64:0] mul_p;

    always_comb begin
        mul_a = r_k[1];
        mul_b = {r_cur[15], r_cur};
        case (i_cmd.mul_op)
            MUL_CS:    begin mul_a = 48'(r_cur); mul_b = {r_spd[15], r_spd}; end
            MUL_CC:    begin mul_a = 48'(r_cur); mul_b = {r_cur[15], r_cur}; end
            MUL_SS:    begin mul_a = 48'(r_spd); mul_b = {r_spd[15], r_spd}; end
            MUL_K1I:   begin mul_a = r_k[1]; mul_b = {r_cur[15], r_cur}; end
            MUL_K2W:   begin mul_a = r_k[2]; mul_b = {r_spd[15], r_spd}; end
            MUL_K3_HI: begin mul_a = r_k[3]; mul_b = {r_pcs[31], r_pcs[31:16]}; end
            MUL_K3_LO: begin mul_a = r_k[3]; mul_b = {1'b0, r_pcs[15:0]}; end
            MUL_K4_HI: begin mul_a = r_k[4]; mul_b = {r_pcc[31], r_pcc[31:16]}; end
            MUL_K4_LO: begin mul_a = r_k[4]; mul_b = {1'b0, r_pcc[15:0]}; end
            MUL_K5_HI: begin mul_a = r_k[5]; mul_b = {r_pss[31], r_pss[31:16]}; end
            MUL_K5_LO: begin mul_a = r_k[5]; mul_b = {1'b0, r_pss[15:0]}; end
            MUL_AC0:   begin mul_a = 48'(r_qa); mul_b = {1'b0, r_qc[15:0]}; end
            MUL_AC1:   begin mul_a = 48'(r_qa); mul_b = {1'b0, r_qc[31:16]}; end
            MUL_AC2:   begin mul_a = 48'(r_qa); mul_b = 17'($signed(r_qc[39:32])); end
            MUL_BB0:   begin mul_a = 48'(r_qb); mul_b = {1'b0, r_qb[15:0]}; end
            MUL_BB1:   begin mul_a = 48'(r_qb); mul_b = {1'b0, r_qb[31:16]}; end
            MUL_BB2:   begin mul_a = 48'(r_qb); mul_b = 17'($signed(r_qb[39:32])); end
            default:   begin mul_a = r_k[1]; mul_b = {r_cur[15], r_cur}; end
        endcase
        mul_p = mul_a * mul_b;
    end

    // Chunk weight of the registered product.
    logic signed [ACC_W-1:0] prod_ext, prod_sh;

    always_comb begin
        prod_ext = {{(ACC_W-65){r_prod[64]}}, r_prod};
        case (r_acc_op)
            MUL_K3_HI, MUL_K4_HI, MUL_K5_HI, MUL_AC1, MUL_BB1: prod_sh = prod_ext <<< 16;
            MUL_AC2, MUL_BB2:                                  prod_sh = prod_ext <<< 32;
            default:                                           prod_sh = prod_ext;
        endcase
    end

    // Multiplier output register and accumulation of the model terms.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_acc_en <= 1'b0;
        else          r_acc_en <= i_cmd.mul_en;
        r_prod   <= mul_p;
        r_acc_op <= i_cmd.mul_op;
        if (i_cmd.load) begin
            r_cur    <= i_item.motor_current;
            r_spd    <= i_item.motor_speed;
            r_meas   <= i_item.measured_power;
            r_target <= i_item.power_target;
            r_acc_a  <= '0;
            r_acc_b  <= '0;
            r_acc_c  <= ACC_W'(r_k[0]);
            r_ac     <= '0;
            r_bb     <= '0;
        end else if (r_acc_en) begin
            case (r_acc_op)
                MUL_CS: r_pcs <= r_prod[31:0];
                MUL_CC: r_pcc <= r_prod[31:0];
                MUL_SS: r_pss <= r_prod[31:0];
                MUL_K1I, MUL_K4_HI, MUL_K4_LO: r_acc_c <= r_acc_c + prod_sh;
                MUL_K2W, MUL_K3_HI, MUL_K3_LO: r_acc_b <= r_acc_b + prod_sh;
                MUL_K5_HI, MUL_K5_LO:          r_acc_a <= r_acc_a + prod_sh;
                MUL_AC0, MUL_AC1, MUL_AC2:     r_ac <= r_ac + prod_sh[DISC_W-1:0];
                MUL_BB0, MUL_BB1, MUL_BB2:     r_bb <= r_bb + prod_sh[DISC_W-1:0];
                default:                       r_ac <= r_ac;
            endcase
        end
        if (i_cmd.total_en) r_total <= r_acc_a + r_acc_b + r_acc_c;
    end

    // Sample power, running sum and window mean.
    logic signed [55:0] tot_sh;
    logic signed [23:0] sample;
    logic signed [32:0] sum_raw, sum_adj, mean_q;
    logic signed [31:0] sum_sat;
    logic signed [23:0] mean_sat;

    always_comb begin
        tot_sh = r_total[ACC_W-1:40];
        if ((&tot_sh[55:23]) || !(|tot_sh[55:23])) sample = tot_sh[23:0];
        else sample = tot_sh[55] ? 24'sh800000 : 24'sh7FFFFF;
        sum_raw = 33'(r_sum) + 33'(sample);
        if (sum_raw[32] == sum_raw[31]) sum_sat = sum_raw[31:0];
        else sum_sat = sum_raw[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        // Truncation toward zero: bias negative sums before the shift.
        sum_adj = 33'(sum_sat) + (sum_sat[31] ? 33'(AVERAGE_WINDOW - 1) : 33'd0);
        mean_q  = sum_adj >>> WIN_SHIFT;
        if ((&mean_q[32:23]) || !(|mean_q[32:23])) mean_sat = mean_q[23:0];
        else mean_sat = mean_q[32] ? 24'sh800000 : 24'sh7FFFFF;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
            r_mean  <= '0;
        end else if (i_cmd.model_en) begin
            if (r_count == WIN_SHIFT'(AVERAGE_WINDOW - 1)) begin
                r_mean  <= mean_sat;
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= sum_sat;
                r_count <= r_count + 1'b1;
            end
        end
    end

    // Model match and quantized quadratic coefficients.
    logic signed [25:0]      diff;
    logic [25:0]             diff_abs;
    logic signed [ACC_W-1:0] cc_full;

    always_comb begin
        diff     = 26'(r_mean) - $signed({6'd0, r_meas});
        diff_abs = diff[25] ? 26'(-diff) : diff;
        cc_full  = r_acc_c - $signed({36'd0, r_target, 40'd0});
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.match_en) begin
            r_match <= diff_abs < {10'd0, r_tol};
            r_qa    <= sat40(r_acc_a[ACC_W-1:32]);
            r_qb    <= sat40(r_acc_b[ACC_W-1:32]);
            r_qc    <= sat40(cc_full[ACC_W-1:32]);
        end
        if (i_cmd.disc_en) r_disc <= r_bb - (r_ac <<< 2);
    end

    // Square root, two radicand bits a step, and the scale division.
    logic [44:0]        rem_sh, trial;
    logic signed [43:0] root_diff;
    logic [43:0]        unum;
    logic [39:0]        qa_abs;
    logic [40:0]        den;
    logic [44:0]        drem_sh;

    always_comb begin
        rem_sh    = {r_rem[42:0], r_rad[DISC_W-1:DISC_W-2]};
        trial     = {1'b0, r_root, 2'b01};
        root_diff = $signed({2'b00, r_root}) - 44'(r_qb);
        unum      = root_diff[43] ? 44'(-root_diff) : root_diff;
        qa_abs    = r_qa[Q_W-1] ? 40'(-r_qa) : r_qa;
        den       = {qa_abs, 1'b0};
        drem_sh   = {r_drem, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sqrt_init) begin
            r_rad  <= r_disc;
            r_rem  <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad <= r_rad << 2;
            if (rem_sh >= trial) begin
                r_rem  <= rem_sh - trial;
                r_root <= {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh;
                r_root <= {r_root[ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_init) begin
            r_drem <= unum;
            r_quot <= '0;
        end else if (i_cmd.div_step) begin
            if (drem_sh >= {4'd0, den}) begin
                r_drem <= 44'(drem_sh - {4'd0, den});
                r_quot <= {r_quot[14:0], 1'b1};
            end else begin
                r_drem <= drem_sh[43:0];
                r_quot <= {r_quot[14:0], 1'b0};
            end
        end
    end

    // Scale factor and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale     <= SCALE_ONE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.scale_one)      r_scale <= SCALE_ONE;
            else if (i_cmd.scale_div) r_scale <= r_quot;
            if (i_cmd.out_load)       r_out_valid <= 1'b1;
            else if (i_out_ready)     r_out_valid <= 1'b0;
        end
        if (i_cmd.out_load) begin
            r_out.speed_scale     <= r_scale;
            r_out.predicted_power <= r_mean;
            r_out.model_matches   <= r_match;
        end
    end

    // Status to the controller.
    always_comb begin
        o_stat.match       = r_match;
        o_stat.over_target = r_meas > r_target;
        o_stat.disc_ok     = !r_disc[DISC_W-1] && (|r_disc) && (|r_qa);
        o_stat.div_sat     = unum >= {3'd0, den};
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// File: hdl/motor_power_limit_scaler.sv
// ----------------------------------------------------------------------------
// motor_power_limit_scaler: speed scale from a quadratic motor power model
// Averages modeled power over a window and solves for a speed scale factor
// when the model matches the measured power and the power is over target.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// One item is worked on at a time, and the path it takes through the
// controller sets how long it stays. When the model does not match or the
// power is at or below target, it takes eleven passes of the shared 48x17
// multiplier for the model terms and six single steps. When the
// discriminant is not positive or the quantized square term is zero, six
// more passes for a*c and b*b follow; when the quotient saturates to 1.0,
// 42 square-root steps and a check follow as well; and when the division
// runs, 15 division steps and one to store the scale are added. The next
// item can be accepted in the cycle after the result is loaded. A result
// that waits in the output register holds the controller and so blocks the
// input. There is no clearing pass after reset.

module motor_power_limit_scaler import mpls_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_idx,
    input  logic [47:0]   i_cfg_data,
    mpls_in_if.sink       i_in,
    mpls_out_if.source    o_out
);

    t_dp_cmd   cmd;
    t_dp_stat  stat;
    t_in_item  item;
    t_out_item out_item;
    logic      in_ready;
    logic      in_fire;
    logic      out_valid;

    assign in_fire = i_in.valid && in_ready;

    assign item.motor_current  = i_in.motor_current;
    assign item.motor_speed    = i_in.motor_speed;
    assign item.measured_power = i_in.measured_power;
    assign item.power_target   = i_in.power_target;

    mpls_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (in_fire),
        .i_stat     (stat),
        .o_in_ready (in_ready),
        .o_cmd      (cmd)
    );

    mpls_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (cmd),
        .i_item      (item),
        .i_out_ready (o_out.ready),
        .o_stat      (stat),
        .o_out_valid (out_valid),
        .o_out       (out_item)
    );

    assign i_in.ready            = in_ready;
    assign o_out.valid           = out_valid;
    assign o_out.speed_scale     = out_item.speed_scale;
    assign o_out.predicted_power = out_item.predicted_power;
    assign o_out.model_matches   = out_item.model_matches;

    // The scale factor never exceeds 1.0.
    a_scale_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.speed_scale <= SCALE_ONE))
        else $error("speed scale above 1.0");

    // Once an item is taken the block is busy on the next cycle.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> !i_in.ready)
        else $error("input ready right after an accepted item");

    // A result is loaded only when the output register can take it.
    a_out_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !cmd.out_load)
        else $error("output register overwritten while stalled");

endmodule

// File: bench/mpls_checker.sv
// ----------------------------------------------------------------------------
// mpls_checker: result checker of the motor power limit scaler
// Watches the configuration port and both item channels, keeps its own
// copy of the power model state, predicts each result item and compares
// it field by field with what the block delivers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mpls_checker import mpls_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [47:0] i_cfg_data,
    mpls_in_if          i_in,
    mpls_out_if         i_out,
    input  logic        i_done,
    output int          o_fail_count
);

    typedef logic signed [127:0] wide_t;

    // Mirror of the configuration and the model state.
    logic signed [47:0] coef [6];
    logic [15:0]        tol;
    wide_t              power_sum;
    int                 sample_cnt;
    wide_t              mean_power;
    logic [15:0]        scale;

    t_out_item expected_results [$];
    int        fails = 0;
    logic      done_seen = 1'b0;

    assign o_fail_count = fails;

    task automatic report(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fails++;
    endtask

    function automatic wide_t clamp_s(input wide_t v, input int bits);
        wide_t one;
        wide_t hi;
        wide_t lo;
        one = 1;
        hi = (one <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // Work out the result of one item and advance the model state.
    task automatic predict_scale(input t_in_item it, output t_out_item res);
        wide_t cur, spd, meas, tgt, t0, t1, t2, t3, t4, t5, sample, diff;
        wide_t qa, qb, qc, disc, root, trial, unum, den;
        logic  match;
        cur  = it.motor_current;
        spd  = it.motor_speed;
        meas = {108'b0, it.measured_power};
        tgt  = {108'b0, it.power_target};
        t0 = coef[0];
        t1 = coef[1] * cur;
        t2 = coef[2] * spd;
        t3 = coef[3] * cur * spd;
        t4 = coef[4] * (cur * cur);
        t5 = coef[5] * (spd * spd);
        sample = clamp_s((t0 + t1 + t2 + t3 + t4 + t5) >>> 40, 24);

        // Windowed mean: the sum is cleared each time a window completes.
        power_sum = clamp_s(power_sum + sample, 32);
        sample_cnt++;
        if (sample_cnt >= AVERAGE_WINDOW) begin
            mean_power = clamp_s(power_sum / AVERAGE_WINDOW, 24);
            power_sum  = 0;
            sample_cnt = 0;
        end

        diff  = mean_power - meas;
        if (diff < 0) diff = -diff;
        match = diff < wide_t'({112'b0, tol});

        if (match) begin
            if (meas > tgt) begin
                qa = clamp_s(t5 >>> 32, 40);
                qb = clamp_s((t2 + t3) >>> 32, 40);
                qc = clamp_s((t0 + t1 + t4 - (tgt <<< 40)) >>> 32, 40);
                disc = qb * qb - 4 * qa * qc;
                // A positive discriminant and a nonzero square term are needed.
                if (disc > 0 && qa != 0) begin
                    root = 0;
                    for (int b = 41; b >= 0; b--) begin
                        trial = root | (wide_t'(1) <<< b);
                        if (trial * trial <= disc) root = trial;
                    end
                    unum = root - qb;
                    if (unum < 0) unum = -unum;
                    den = (qa < 0) ? -2 * qa : 2 * qa;
                    if (unum >= den) scale = SCALE_ONE;
                    else scale = 16'((unum <<< 15) / den);
                end
            end else begin
                scale = SCALE_ONE;
            end
        end

        res.speed_scale     = scale;
        res.predicted_power = mean_power[23:0];
        res.model_matches   = match;
    endtask

    always @(posedge i_clk) begin
        t_in_item  it;
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            foreach (coef[k]) coef[k] = '0;
            tol        = TOL_RESET;
            power_sum  = 0;
            sample_cnt = 0;
            mean_power = 0;
            scale      = SCALE_ONE;
            expected_results.delete();
        end else begin
            // Compare a delivered result with the oldest expectation.
            if (i_out.valid && i_out.ready) begin
                got.speed_scale     = i_out.speed_scale;
                got.predicted_power = i_out.predicted_power;
                got.model_matches   = i_out.model_matches;
                if (expected_results.size() == 0) begin
                    report("result item with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (got.speed_scale !== want.speed_scale)
                        report($sformatf("speed_scale %0d, expected %0d",
                                         got.speed_scale, want.speed_scale));
                    if (got.predicted_power !== want.predicted_power)
                        report($sformatf("predicted_power %0d, expected %0d",
                                         got.predicted_power, want.predicted_power));
                    if (got.model_matches !== want.model_matches)
                        report($sformatf("model_matches %0d, expected %0d",
                                         got.model_matches, want.model_matches));
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MATCH_TOL) tol = i_cfg_data[15:0];
                else if (i_cfg_idx < CFG_MATCH_TOL) coef[i_cfg_idx] = i_cfg_data;
            end
            if (i_in.valid && i_in.ready) begin
                it.motor_current  = i_in.motor_current;
                it.motor_speed    = i_in.motor_speed;
                it.measured_power = i_in.measured_power;
                it.power_target   = i_in.power_target;
                predict_scale(it, want);
                expected_results.push_back(want);
            end
            // At the end every expectation still waiting is a failure.
            if (i_done && !done_seen) begin
                done_seen = 1'b1;
                while (expected_results.size() > 0) begin
                    void'(expected_results.pop_front());
                    report("expected result item never delivered");
                end
            end
        end
    end

endmodule

// File: bench/motor_power_limit_scaler_tb.sv
// ----------------------------------------------------------------------------
// motor_power_limit_scaler_tb: testbench of the motor power limit scaler
// Drives directed and random items through several coefficient settings and
// handshake patterns, with a long output stall and a full drain, while the
// checker predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module motor_power_limit_scaler_tb import mpls_pkg::*; ();

    localparam int  WATCHDOG_LIMIT = 3000;
    localparam int  HOLD_CYCLES    = 400;
    localparam longint Q_ONE       = 64'sd1 << 40;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = '0;
    logic [47:0] cfg_data = '0;
    logic        run_done = 1'b0;
    int          fail_count;

    mpls_in_if  in_ch ();
    mpls_out_if out_ch ();

    // Handshake pattern: 0 none, 1 sender idles, 2 receiver stalls, 3 both.
    int   idle_mode = 0;
    int   hold_requests = 0;
    int   items_sent = 0;
    int   items_recv = 0;
    int   quiet_cycles = 0;
    logic signed [23:0] last_pred = '0;

    motor_power_limit_scaler i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    mpls_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .i_done       (run_done),
        .o_fail_count (fail_count)
    );

    always #10 i_clk = ~i_clk;

    // Receiver: random stalls by mode, plus long hold-offs on request.
    initial begin
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_requests != hold_seen) begin
                hold_seen = hold_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_mode == 2) begin
                out_ch.ready <= ($urandom_range(0, 99) >= 52);
            end else if (idle_mode == 3) begin
                out_ch.ready <= ($urandom_range(0, 99) >= 34);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Count results and remember the latest predicted power.
    always @(posedge i_clk) begin
        if (out_ch.valid && out_ch.ready) begin
            items_recv++;
            last_pred <= out_ch.predicted_power;
        end
    end

    // Watchdog: too long without any item moving ends the run.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [47:0] value);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_model(input longint k0, k1, k2, k3, k4, k5,
                              input logic [15:0] tolerance);
        write_reg(CFG_COEF_CONSTANT,   k0[47:0]);
        write_reg(CFG_COEF_CURRENT,    k1[47:0]);
        write_reg(CFG_COEF_SPEED,      k2[47:0]);
        write_reg(CFG_COEF_CROSS,      k3[47:0]);
        write_reg(CFG_COEF_CURRENT_SQ, k4[47:0]);
        write_reg(CFG_COEF_SPEED_SQ,   k5[47:0]);
        write_reg(CFG_MATCH_TOL,       {32'b0, tolerance});
    endtask

    // Offer one item, idling first by mode, and wait until it is taken.
    task automatic send_item(input int cur, input int spd, input int meas, input int tgt);
        int idle_pct;
        idle_pct = (idle_mode == 1) ? 52 : ((idle_mode == 3) ? 34 : 0);
        while ($urandom_range(0, 99) < idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid          <= 1'b1;
        in_ch.motor_current  <= 16'(cur);
        in_ch.motor_speed    <= 16'(spd);
        in_ch.measured_power <= 20'(meas);
        in_ch.power_target   <= 20'(tgt);
        do @(posedge i_clk); while (!in_ch.ready);
        items_sent++;
    endtask

    // Wait until every item sent has its result, then settle a little.
    task automatic drain();
        in_ch.valid <= 1'b0;
        do @(posedge i_clk); while (items_recv != items_sent);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic int rand_span(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    // Random item: the measured power mostly sits near the last prediction
    // so the model matches, and the target straddles the measured power.
    task automatic send_random(input int span, input int tolerance);
        int cur, spd, meas, tgt, sel;
        cur = rand_span(span);
        spd = ($urandom_range(0, 19) == 0) ? 0 : rand_span(span);
        sel = $urandom_range(0, 9);
        if (sel < 7) meas = int'(last_pred) + rand_span(tolerance + 2);
        else meas = $urandom_range(0, 1048575);
        if (meas < 0) meas = 0;
        if (meas > 1048575) meas = 1048575;
        sel = $urandom_range(0, 9);
        if (sel < 5) tgt = meas - int'($urandom_range(1, 4000));
        else if (sel < 8) tgt = meas + int'($urandom_range(0, 2000));
        else tgt = $urandom_range(0, 1048575);
        if (tgt < 0) tgt = 0;
        if (tgt > 1048575) tgt = 1048575;
        send_item(cur, spd, meas, tgt);
    endtask

    task automatic load_random_model(input logic [15:0] tolerance);
        longint k0, k1, k2, k3, k4, k5;
        k0 = longint'($urandom_range(0, 4000)) * Q_ONE;
        k1 = longint'(rand_span(1 << 30));
        k2 = longint'(rand_span(1 << 30));
        k3 = longint'(rand_span(1 << 24));
        k4 = longint'($urandom_range(1 << 26, 1 << 28));
        k5 = longint'($urandom_range(1 << 26, 1 << 28));
        load_model(k0, k1, k2, k3, k4, k5, tolerance);
    endtask

    initial begin
        longint kmax, kmin;
        kmax = (64'sd1 <<< 47) - 1;
        kmin = -(64'sd1 <<< 47);
        in_ch.valid          = 1'b0;
        in_ch.motor_current  = '0;
        in_ch.motor_speed    = '0;
        in_ch.measured_power = '0;
        in_ch.power_target   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items at reset settings: the mean is zero, so small measured
        // powers match. The square term is zero, so solving always holds.
        send_item(0, 0, 0, 0);
        send_item(-32768, -32768, 1048575, 0);
        send_item(32767, 32767, 0, 1048575);
        send_item(32767, -32768, 100, 50);
        send_item(5, 5, 100, 200);
        send_item(0, 0, 2000, 0);
        send_item(-1, 1, 1279, 1279);
        send_item(1, -1, 1280, 0);
        send_item(-32768, 32767, 1048575, 1048575);
        send_item(0, 0, 500, 0);
        drain();

        // Realistic model, no idling, one long output stall.
        load_random_model(16'd1280);
        for (int n = 0; n < 300; n++) begin
            if (n == 150) hold_requests++;
            send_random(2000, 1280);
        end
        drain();

        // Directed: in the first item zero speed under a real model makes the square term zero.
        send_item(100, 0, int'(last_pred), 0);
        send_item(-2000, 2000, int'(last_pred), 0);
        send_item(2000, -2000, int'(last_pred), 1048575);
        drain();

        idle_mode = 1;
        load_random_model(16'hFFFF);
        repeat (250) send_random(2000, 4000);
        drain();

        idle_mode = 2;
        load_random_model(16'd2560);
        for (int n = 0; n < 250; n++) begin
            if (n == 125) drain();
            send_random(2000, 2560);
        end
        drain();

        idle_mode = 3;
        load_random_model(16'd1280);
        repeat (250) send_random(2000, 1280);
        drain();

        // Extreme coefficients and full-range fields drive every saturation.
        idle_mode = 0;
        load_model(kmax, kmax, kmax, kmax, kmax, kmax, 16'd0);
        repeat (150) send_random(32767, 1000);
        drain();
        idle_mode = 3;
        load_model(kmin, kmin, kmin, kmin, kmin, kmin, 16'hFFFF);
        repeat (150) send_random(32767, 100000);
        drain();

        repeat (100) @(posedge i_clk);
        run_done <= 1'b1;
        repeat (2) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
